>>> design/ioct_pkg.sv
// Shared constants, codes and types for the in-order completion tracker.
// No dependencies; imported by every module of the block but ioct_ram.

package ioct_pkg;

  // Id and result field widths
  localparam int ID_W      = 64;
  localparam int CNT_OUT_W = 11;
  localparam int STAT_W    = 2;

  // Done-flag slots; slot = id mod SLOTS, taken as the low id bits (power of two)
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Depth of the queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_IGNORED  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_DROPPED  = 2'd2;

  // Queued word: id plus its front-end classification
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            is_zero;
  } fe_word_t;

  // Back-end control seen by the front
  typedef struct packed {
    logic take;      // back pulls the oldest queued word this cycle
    logic clearing;  // flag memory clearing pass in progress
  } be_ctl_t;

endpackage

>>> design/ioct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module ioct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/ioct_front.sv
// Front end: accepts completion words, tags zero ids, queues them for the back.
// Depends on ioct_pkg.

module ioct_front import ioct_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [ID_W-1:0] done_id,
  output logic            full,
  output logic            fe_valid,
  output fe_word_t        fe_word,
  input  be_ctl_t         be_ctl
);

  fe_word_t          q [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr;
  logic [FQ_AW-1:0]  rd_ptr;
  logic [FQ_CW-1:0]  count;
  logic              wr_en;
  logic              rd_en;

  // Handshake; nothing is taken while the flag memory is being cleared
  assign full     = (count == FQ_CW'(FQ_DEPTH)) || be_ctl.clearing;
  assign wr_en    = push && !full;
  assign fe_valid = (count != '0);
  assign rd_en    = be_ctl.take && fe_valid;
  assign fe_word  = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr].id      <= done_id;
      q[wr_ptr].is_zero <= (done_id == '0);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/ioct_back.sv
// Back end: window check, done-flag update, watermark advance, result register.
// Depends on ioct_pkg and ioct_ram.

module ioct_back import ioct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fe_valid,
  input  fe_word_t             fe_word,
  output be_ctl_t              be_ctl,
  input  logic                 pop,
  output logic                 empty,
  output logic [ID_W-1:0]      watermark,
  output logic [CNT_OUT_W-1:0] retired_count,
  output logic [STAT_W-1:0]    status
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_READ  = 6'b001000,
    ST_TEST  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   clr_idx;
  logic [ID_W-1:0]     wm;
  logic [ID_W-1:0]     cur_id;
  logic                cur_zero;
  logic [ID_W-1:0]     diff;
  logic                borrow;
  logic [CNT_W-1:0]    cnt;
  logic [STAT_W-1:0]   res_status;

  logic                out_valid;
  logic [ID_W-1:0]     out_wm;
  logic [CNT_W-1:0]    out_cnt;
  logic [STAT_W-1:0]   out_status;
  logic [63:0]         cnt_wide;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic                ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  logic                ram_rdata;

  logic                in_window;
  logic                advance;
  logic                out_load;
  logic [SLOT_W-1:0]   wm_slot;

  // One flag per slot; only slots inside the window may be set
  ioct_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign wm_slot   = wm[SLOT_W-1:0];
  // 1 <= id - wm <= SLOTS
  assign in_window = !cur_zero && !borrow && (diff != '0) && (diff <= ID_W'(SLOTS));
  // next slot is done, step limit not reached, id space not exhausted
  assign advance   = ram_rdata && (cnt != CNT_W'(SLOTS)) && !(&wm);
  assign out_load  = (state == ST_DONE) && (!out_valid || pop);

  assign be_ctl.take     = (state == ST_IDLE) && fe_valid;
  assign be_ctl.clearing = (state == ST_CLEAR);

  // Flag memory access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wm_slot + 1'b1;
    ram_wdata = 1'b0;
    ram_raddr = wm_slot + 1'b1;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      ST_CHECK: begin
        ram_we    = in_window;
        ram_waddr = cur_id[SLOT_W-1:0];
        ram_wdata = 1'b1;
      end
      ST_TEST: begin
        // clear the retired slot, fetch the one after it
        ram_we    = advance;
        ram_raddr = wm_slot + SLOT_W'(2);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      wm      <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_W'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (fe_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (in_window) begin
            state <= ST_READ;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (advance) begin
            wm <= wm + 1'b1;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-word working registers
  always_ff @(posedge clk) begin
    if (be_ctl.take) begin
      cur_id           <= fe_word.id;
      cur_zero         <= fe_word.is_zero;
      {borrow, diff}   <= {1'b0, fe_word.id} - {1'b0, wm};
      cnt              <= '0;
    end
    if (state == ST_CHECK) begin
      if (cur_zero || borrow || (diff == '0)) begin
        res_status <= STATUS_IGNORED;
      end else if (!in_window) begin
        res_status <= STATUS_DROPPED;
      end else begin
        res_status <= STATUS_ACCEPTED;
      end
    end
    if ((state == ST_TEST) && advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_wm     <= wm;
      out_cnt    <= cnt;
      out_status <= res_status;
    end
  end

  assign cnt_wide      = 64'(out_cnt);
  assign empty         = !out_valid;
  assign watermark     = out_wm;
  assign retired_count = cnt_wide[CNT_OUT_W-1:0];
  assign status        = out_status;

endmodule

>>> design/in_order_completion_tracker.sv
// Top level of the in-order completion tracker: front queue plus back engine.
// Depends on ioct_pkg, ioct_front, ioct_back (and ioct_ram through the back).
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------
//  input    | push / full            | done_id[63:0]
//  result   | empty / pop            | watermark[63:0], retired_count[10:0],
//           |                        | status[1:0]
//
// After reset the flag memory is cleared one slot a cycle: full stays high
// until all SLOTS (1024) slots are clear. A word then steps through idle,
// check, done if ignored or dropped; if accepted, idle, check, read, a test
// per id retired in the flag memory's read-test-clear loop, a last test and
// done. The two-word input queue keeps taking words while the back works or
// a result waits on pop; the back waits in done for a free result register.

module in_order_completion_tracker import ioct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [ID_W-1:0]      done_id,
  output logic                 empty,
  input  logic                 pop,
  output logic [ID_W-1:0]      watermark,
  output logic [CNT_OUT_W-1:0] retired_count,
  output logic [STAT_W-1:0]    status
);

  logic     fe_valid;
  fe_word_t fe_word;
  be_ctl_t  be_ctl;

  // Accept and classify
  ioct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .done_id  (done_id),
    .full     (full),
    .fe_valid (fe_valid),
    .fe_word  (fe_word),
    .be_ctl   (be_ctl)
  );

  // Window check, flag update, retirement
  ioct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .fe_valid      (fe_valid),
    .fe_word       (fe_word),
    .be_ctl        (be_ctl),
    .pop           (pop),
    .empty         (empty),
    .watermark     (watermark),
    .retired_count (retired_count),
    .status        (status)
  );

endmodule

>>> design/ioct_checker.sv
// Port-level checks for the in-order completion tracker, bound to the top.
// Depends on ioct_pkg and in_order_completion_tracker.

module ioct_checker import ioct_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 empty,
  input logic                 pop,
  input logic [ID_W-1:0]      watermark,
  input logic [CNT_OUT_W-1:0] retired_count,
  input logic [STAT_W-1:0]    status
);

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == STATUS_ACCEPTED || status == STATUS_IGNORED ||
                status == STATUS_DROPPED))
    else $error("undefined status code on result word");

  // Ignored or dropped words never retire anything
  a_no_retire: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != STATUS_ACCEPTED) |-> (retired_count == '0))
    else $error("retire count on a word that was not accepted");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(watermark) && $stable(status) &&
                          $stable(retired_count)))
    else $error("result word changed while waiting");

  // The watermark never moves back between shown results
  a_monotonic: assert property (@(posedge clk) disable iff (rst)
    (!empty && $past(!empty) && $past(!rst)) |-> (watermark >= $past(watermark)))
    else $error("watermark decreased");

endmodule

bind in_order_completion_tracker ioct_checker u_ioct_checker (.*);
